@@ rtl/lru_predicted_delay_promotion_assert.svh @@
// Assertion macros used by the store's top-level RTL file.
`ifndef LRU_PREDICTED_DELAY_PROMOTION_ASSERT_SVH
`define LRU_PREDICTED_DELAY_PROMOTION_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define LPDP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define LPDP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lpdp_pkg.sv @@
// Shared constants and types of the LRU store with predicted-delay promotion.
`timescale 1ns / 1ps
package lpdp_pkg;

    // Field widths
    localparam int KEY_W      = 32;
    localparam int TIME_W     = 32;
    localparam int AGE_W      = 40;
    localparam int AGE_FRAC   = 8;
    localparam int PCT_W      = 16;
    localparam int PCT_FRAC   = 16;
    localparam int LIM_CFG_W  = 9;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int PRED_W     = AGE_W + 1;

    // Parameter defaults
    localparam int ENTRIES_DEF   = 256;
    localparam int FRAC_BITS_DEF = 16;

    // Register reset values
    localparam logic [PCT_W-1:0]     PCT_RESET   = 16'd58982;
    localparam logic [LIM_CFG_W-1:0] LIMIT_RESET = 9'd256;

    // Age filter weights, Q0.16 (0.15 and 0.85)
    localparam logic [PCT_W-1:0] W_NEW = 16'd9830;
    localparam logic [PCT_W-1:0] W_OLD = 16'd55706;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_PERCENTILE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE     = 1'b1;

    // Actions
    localparam logic ACT_GET    = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Kind of work under way for the current beat
    typedef enum logic [1:0] {
        OP_REMOVE = 2'd0,
        OP_HIT    = 2'd1,
        OP_EVICT  = 2'd2,
        OP_INSERT = 2'd3
    } op_t;

endpackage

@@ rtl/lpdp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lpdp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/lpdp_mul.sv @@
// Shared multiplier with a registered product.
`timescale 1ns / 1ps
module lpdp_mul #(
    parameter int B_W = 17
) (
    input  logic                          clk,
    input  logic [lpdp_pkg::AGE_W-1:0]    a,
    input  logic [B_W-1:0]                b,
    output logic [lpdp_pkg::AGE_W+B_W-1:0] prod
);

    // Multiply and register
    always_ff @(posedge clk)
    begin
        prod <= (lpdp_pkg::AGE_W + B_W)'(a) * (lpdp_pkg::AGE_W + B_W)'(b);
    end

endmodule

@@ rtl/lru_predicted_delay_promotion.sv @@
// LRU object store with predicted-delay promotion: top level and sequencer.
//
// One beat is handled at a time; in_ready is high only while idle, and the
// accepting cycle is spent in idle. Every beat first scans the key RAM at one
// slot a cycle (pipelined compare); a hit ends the scan early. After the scan:
// - a remove that finds its key reads the slot, unlinks it and finishes; an
//   absent key finishes at once.
// - a hit reads the slot and makes three passes through the shared multiplier,
//   then moves the entry to the head when it is promoted and not already there.
// - a miss inserts at a free slot and links it at the head. When the store is
//   full it first evicts the tail; two multiplier passes update the age
//   estimate when the evicted entry had never been hit.
// The result is held in an output register until taken. No clearing pass
// runs after reset.
`timescale 1ns / 1ps
`include "lru_predicted_delay_promotion_assert.svh"
module lru_predicted_delay_promotion #(
    parameter int ENTRIES   = lpdp_pkg::ENTRIES_DEF,
    parameter int FRAC_BITS = lpdp_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lpdp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lpdp_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              action,
    input  logic [lpdp_pkg::KEY_W-1:0]        obj_key,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              hit,
    output logic                              promoted,
    output logic                              evicted,
    output logic [lpdp_pkg::KEY_W-1:0]        evicted_key,
    output logic                              removed
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int LIM_W  = (CNT_W > lpdp_pkg::LIM_CFG_W) ? CNT_W : lpdp_pkg::LIM_CFG_W;
    localparam int SC_W   = FRAC_BITS + 1;
    localparam int MB_W   = (SC_W > lpdp_pkg::PCT_W) ? SC_W : lpdp_pkg::PCT_W;
    localparam int PROD_W = lpdp_pkg::AGE_W + MB_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int TW     = lpdp_pkg::TIME_W;
    localparam int META_W = 3 * TW + 1 + SC_W;
    // Offsets inside a metadata word
    localparam int M_SC  = 0;
    localparam int M_SEEN = SC_W;
    localparam int M_INS = SC_W + 1;
    localparam int M_LP  = M_INS + TW;
    localparam int M_LH  = M_LP + TW;
    localparam logic [IDX_W:0]  SCAN_END  = (IDX_W + 1)'(ENTRIES);
    localparam logic [LIM_W-1:0] LIM_MAX  = LIM_W'(ENTRIES);
    localparam logic [SC_W-1:0] SCALE_ONE = SC_W'(1) << FRAC_BITS;

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_SCAN = 16'h0002,
        S_RD   = 16'h0004,
        S_RDW  = 16'h0008,
        S_M1   = 16'h0010,
        S_M2   = 16'h0020,
        S_M3   = 16'h0040,
        S_DEC  = 16'h0080,
        S_A1   = 16'h0100,
        S_A2   = 16'h0200,
        S_A3   = 16'h0400,
        S_UNL  = 16'h0800,
        S_INS  = 16'h1000,
        S_PH1  = 16'h2000,
        S_PH2  = 16'h4000,
        S_DONE = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    lpdp_pkg::op_t op_reg, op_next;

    logic [lpdp_pkg::PCT_W-1:0]     pct_reg, pct_next;
    logic [lpdp_pkg::LIM_CFG_W-1:0] lim_reg, lim_next;
    logic                           act_reg, act_next;
    logic [lpdp_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [TW-1:0]                  clk_reg, clk_next;
    logic [lpdp_pkg::AGE_W-1:0]     ea_reg, ea_next;
    logic [IDX_W-1:0]               head_reg, head_next;
    logic [IDX_W-1:0]               tail_reg, tail_next;
    logic [CNT_W-1:0]               occ_reg, occ_next;
    logic [ENTRIES-1:0]             valid_reg, valid_next;
    logic [IDX_W:0]                 scan_reg, scan_next;
    logic                           cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]               cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]               slot_reg, slot_next;
    logic [IDX_W-1:0]               free_reg, free_next;
    logic                           free_vld_reg, free_vld_next;
    logic [TW-1:0]                  lh_reg, lh_next;
    logic [TW-1:0]                  lp_reg, lp_next;
    logic [TW-1:0]                  ins_reg, ins_next;
    logic [SC_W-1:0]                sc_reg, sc_next;
    logic [IDX_W-1:0]               p_reg, p_next;
    logic [IDX_W-1:0]               n_reg, n_next;
    logic [lpdp_pkg::KEY_W-1:0]     evk_reg, evk_next;
    logic [lpdp_pkg::PRED_W-1:0]    pred_reg, pred_next;
    logic [ACC_W-1:0]               acc_reg, acc_next;
    logic                           empty_reg, empty_next;
    logic                           r_hit_reg, r_hit_next;
    logic                           r_promo_reg, r_promo_next;
    logic                           r_ev_reg, r_ev_next;
    logic [lpdp_pkg::KEY_W-1:0]     r_evk_reg, r_evk_next;
    logic                           r_rem_reg, r_rem_next;
    logic                           ov_reg, ov_next;
    logic                           o_hit_reg, o_hit_next;
    logic                           o_promo_reg, o_promo_next;
    logic                           o_ev_reg, o_ev_next;
    logic [lpdp_pkg::KEY_W-1:0]     o_evk_reg, o_evk_next;
    logic                           o_rem_reg, o_rem_next;

    // RAM ports
    logic [IDX_W-1:0]           rd_addr;
    logic                       key_we, meta_we, next_we, prev_we;
    logic [lpdp_pkg::KEY_W-1:0] key_rdata;
    logic [META_W-1:0]          meta_wdata, meta_rdata;
    logic [IDX_W-1:0]           next_waddr, next_wdata, next_rdata;
    logic [IDX_W-1:0]           prev_waddr, prev_wdata, prev_rdata;

    // Shared multiplier
    logic [lpdp_pkg::AGE_W-1:0] mul_a;
    logic [MB_W-1:0]            mul_b;
    logic [PROD_W-1:0]          prod;

    // Working values
    logic                       scan_live, match, full, promote;
    logic [LIM_W-1:0]           lim_eff;
    logic [TW-1:0]              elapsed;
    logic [TW-1:0]              interval;
    logic signed [lpdp_pkg::AGE_W+1:0] remaining, pred_s;
    logic [ACC_W-1:0]           age_sum;

    lpdp_ram #(.WIDTH(lpdp_pkg::KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .clk(clk), .we(key_we), .waddr(slot_reg), .wdata(key_reg),
        .raddr(rd_addr), .rdata(key_rdata)
    );

    lpdp_ram #(.WIDTH(META_W), .DEPTH(ENTRIES)) u_meta_ram (
        .clk(clk), .we(meta_we), .waddr(slot_reg), .wdata(meta_wdata),
        .raddr(rd_addr), .rdata(meta_rdata)
    );

    lpdp_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_next_ram (
        .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(rd_addr), .rdata(next_rdata)
    );

    lpdp_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_prev_ram (
        .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
        .raddr(rd_addr), .rdata(prev_rdata)
    );

    lpdp_mul #(.B_W(MB_W)) u_mul (
        .clk(clk), .a(mul_a), .b(mul_b), .prod(prod)
    );

    // Clamp the slot limit and test for a full store
    always_comb
    begin
        lim_eff = LIM_W'(lim_reg);
        if (lim_eff == '0)
        begin
            lim_eff = LIM_W'(1);
        end
        if (lim_eff > LIM_MAX)
        begin
            lim_eff = LIM_MAX;
        end
        full = (LIM_W'(occ_reg) >= lim_eff) && (occ_reg != '0);
    end

    // Scan compare and promotion test
    assign scan_live = scan_reg < SCAN_END;
    assign match     = cmp_vld_reg && valid_reg[cmp_idx_reg] && (key_rdata == key_reg);
    assign elapsed   = clk_reg - lp_reg;
    assign interval  = clk_reg - lh_reg;
    assign remaining = $signed({2'b00, ea_reg})
                     - $signed({2'b00, elapsed, {lpdp_pkg::AGE_FRAC{1'b0}}});
    assign pred_s    = $signed({1'b0, pred_reg});
    assign promote   = (pred_s > remaining) && ({1'b0, pred_reg} < {2'b00, ea_reg});
    assign age_sum   = acc_reg + ACC_W'(prod);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        pct_next     = pct_reg;
        lim_next     = lim_reg;
        act_next     = act_reg;
        key_next     = key_reg;
        clk_next     = clk_reg;
        ea_next      = ea_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        occ_next     = occ_reg;
        valid_next   = valid_reg;
        scan_next    = scan_reg;
        cmp_vld_next = cmp_vld_reg;
        cmp_idx_next = cmp_idx_reg;
        slot_next    = slot_reg;
        free_next    = free_reg;
        free_vld_next = free_vld_reg;
        lh_next      = lh_reg;
        lp_next      = lp_reg;
        ins_next     = ins_reg;
        sc_next      = sc_reg;
        p_next       = p_reg;
        n_next       = n_reg;
        evk_next     = evk_reg;
        pred_next    = pred_reg;
        acc_next     = acc_reg;
        empty_next   = empty_reg;
        r_hit_next   = r_hit_reg;
        r_promo_next = r_promo_reg;
        r_ev_next    = r_ev_reg;
        r_evk_next   = r_evk_reg;
        r_rem_next   = r_rem_reg;
        ov_next      = ov_reg;
        o_hit_next   = o_hit_reg;
        o_promo_next = o_promo_reg;
        o_ev_next    = o_ev_reg;
        o_evk_next   = o_evk_reg;
        o_rem_next   = o_rem_reg;
        rd_addr      = slot_reg;
        key_we       = 1'b0;
        meta_we      = 1'b0;
        meta_wdata   = {clk_reg, clk_reg, clk_reg, 1'b0, SCALE_ONE};
        next_we      = 1'b0;
        next_waddr   = slot_reg;
        next_wdata   = slot_reg;
        prev_we      = 1'b0;
        prev_waddr   = slot_reg;
        prev_wdata   = slot_reg;
        mul_a        = '0;
        mul_b        = '0;

        // Take configuration writes
        if (cfg_we)
        begin
            case (cfg_addr)
                lpdp_pkg::CFG_PERCENTILE: pct_next = cfg_wdata;
                lpdp_pkg::CFG_ACTIVE:     lim_next = cfg_wdata[lpdp_pkg::LIM_CFG_W-1:0];
                default:                  pct_next = pct_reg;
            endcase
        end

        // Drop the output beat once taken
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next      = action;
                    key_next      = obj_key;
                    scan_next     = '0;
                    cmp_vld_next  = 1'b0;
                    free_vld_next = 1'b0;
                    r_hit_next    = 1'b0;
                    r_promo_next  = 1'b0;
                    r_ev_next     = 1'b0;
                    r_evk_next    = '0;
                    r_rem_next    = 1'b0;
                    if (action == lpdp_pkg::ACT_GET)
                    begin
                        clk_next = clk_reg + TW'(1);
                    end
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Issue one slot a cycle, compare the previous one
                rd_addr = scan_reg[IDX_W-1:0];
                if (scan_live)
                begin
                    scan_next = scan_reg + (IDX_W + 1)'(1);
                end
                cmp_vld_next = scan_live;
                cmp_idx_next = scan_reg[IDX_W-1:0];
                if (cmp_vld_reg && !valid_reg[cmp_idx_reg] && !free_vld_reg)
                begin
                    free_vld_next = 1'b1;
                    free_next     = cmp_idx_reg;
                end
                if (match)
                begin
                    slot_next  = cmp_idx_reg;
                    op_next    = (act_reg == lpdp_pkg::ACT_REMOVE) ?
                                 lpdp_pkg::OP_REMOVE : lpdp_pkg::OP_HIT;
                    state_next = S_RD;
                end
                else if (!cmp_vld_reg && !scan_live)
                begin
                    if (act_reg == lpdp_pkg::ACT_REMOVE)
                    begin
                        state_next = S_DONE;
                    end
                    else if (full)
                    begin
                        slot_next  = tail_reg;
                        op_next    = lpdp_pkg::OP_EVICT;
                        state_next = S_RD;
                    end
                    else
                    begin
                        slot_next  = free_reg;
                        op_next    = lpdp_pkg::OP_INSERT;
                        state_next = S_INS;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_RDW;
            end
            S_RDW:
            begin
                // Capture the slot's metadata and links
                lh_next    = meta_rdata[M_LH +: TW];
                lp_next    = meta_rdata[M_LP +: TW];
                ins_next   = meta_rdata[M_INS +: TW];
                sc_next    = meta_rdata[M_SC +: SC_W];
                p_next     = prev_rdata;
                n_next     = next_rdata;
                evk_next   = key_rdata;
                empty_next = 1'b0;
                case (op_reg)
                    lpdp_pkg::OP_HIT:
                    begin
                        r_hit_next = 1'b1;
                        state_next = S_M1;
                    end
                    lpdp_pkg::OP_EVICT:
                    begin
                        state_next = meta_rdata[M_SEEN] ? S_UNL : S_A1;
                    end
                    default:
                    begin
                        state_next = S_UNL;
                    end
                endcase
            end
            S_M1:
            begin
                // interval * percentile
                mul_a      = lpdp_pkg::AGE_W'(interval);
                mul_b      = MB_W'(pct_reg);
                state_next = S_M2;
            end
            S_M2:
            begin
                // t * scale
                mul_a      = prod[lpdp_pkg::AGE_FRAC +: lpdp_pkg::AGE_W];
                mul_b      = MB_W'(sc_reg);
                state_next = S_M3;
            end
            S_M3:
            begin
                // Hold the prediction, then scale * percentile
                pred_next  = prod[FRAC_BITS +: lpdp_pkg::PRED_W];
                mul_a      = lpdp_pkg::AGE_W'(sc_reg);
                mul_b      = MB_W'(pct_reg);
                state_next = S_DEC;
            end
            S_DEC:
            begin
                // Write back the hit entry and decide on promotion
                meta_we      = 1'b1;
                meta_wdata   = {clk_reg, (promote ? clk_reg : lp_reg), ins_reg, 1'b1,
                                prod[lpdp_pkg::PCT_FRAC +: SC_W]};
                r_promo_next = promote;
                if (promote && (head_reg != slot_reg))
                begin
                    state_next = S_UNL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_A1:
            begin
                mul_a      = {clk_reg - ins_reg, {lpdp_pkg::AGE_FRAC{1'b0}}};
                mul_b      = MB_W'(lpdp_pkg::W_NEW);
                state_next = S_A2;
            end
            S_A2:
            begin
                acc_next   = ACC_W'(prod);
                mul_a      = ea_reg;
                mul_b      = MB_W'(lpdp_pkg::W_OLD);
                state_next = S_A3;
            end
            S_A3:
            begin
                ea_next    = age_sum[lpdp_pkg::PCT_FRAC +: lpdp_pkg::AGE_W];
                state_next = S_UNL;
            end
            S_UNL:
            begin
                // Unlink the slot unless it is the only entry
                if (!((head_reg == slot_reg) && (tail_reg == slot_reg)))
                begin
                    if (head_reg == slot_reg)
                    begin
                        head_next = n_reg;
                    end
                    else
                    begin
                        next_we    = 1'b1;
                        next_waddr = p_reg;
                        next_wdata = n_reg;
                    end
                    if (tail_reg == slot_reg)
                    begin
                        tail_next = p_reg;
                    end
                    else
                    begin
                        prev_we    = 1'b1;
                        prev_waddr = n_reg;
                        prev_wdata = p_reg;
                    end
                end
                case (op_reg)
                    lpdp_pkg::OP_REMOVE:
                    begin
                        valid_next[slot_reg] = 1'b0;
                        occ_next             = occ_reg - CNT_W'(1);
                        r_rem_next           = 1'b1;
                        state_next           = S_DONE;
                    end
                    lpdp_pkg::OP_EVICT:
                    begin
                        valid_next[slot_reg] = 1'b0;
                        occ_next             = occ_reg - CNT_W'(1);
                        r_ev_next            = 1'b1;
                        r_evk_next           = evk_reg;
                        state_next           = S_INS;
                    end
                    default:
                    begin
                        state_next = S_PH1;
                    end
                endcase
            end
            S_INS:
            begin
                // Fill the slot with the new key
                key_we               = 1'b1;
                meta_we              = 1'b1;
                valid_next[slot_reg] = 1'b1;
                empty_next           = (occ_reg == '0);
                occ_next             = occ_reg + CNT_W'(1);
                state_next           = S_PH1;
            end
            S_PH1:
            begin
                prev_we    = 1'b1;
                next_we    = 1'b1;
                next_wdata = empty_reg ? slot_reg : head_reg;
                if (empty_reg)
                begin
                    head_next  = slot_reg;
                    tail_next  = slot_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PH2;
                end
            end
            S_PH2:
            begin
                prev_we    = 1'b1;
                prev_waddr = head_reg;
                head_next  = slot_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Load the output beat when the register is free
                if (!ov_reg || out_ready)
                begin
                    ov_next      = 1'b1;
                    o_hit_next   = r_hit_reg;
                    o_promo_next = r_promo_reg;
                    o_ev_next    = r_ev_reg;
                    o_evk_next   = r_evk_reg;
                    o_rem_next   = r_rem_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pct_reg   <= lpdp_pkg::PCT_RESET;
            lim_reg   <= lpdp_pkg::LIMIT_RESET;
            clk_reg   <= '0;
            ea_reg    <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= '0;
            valid_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pct_reg   <= pct_next;
            lim_reg   <= lim_next;
            clk_reg   <= clk_next;
            ea_reg    <= ea_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
            valid_reg <= valid_next;
            ov_reg    <= ov_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        act_reg      <= act_next;
        key_reg      <= key_next;
        scan_reg     <= scan_next;
        cmp_vld_reg  <= cmp_vld_next;
        cmp_idx_reg  <= cmp_idx_next;
        slot_reg     <= slot_next;
        free_reg     <= free_next;
        free_vld_reg <= free_vld_next;
        lh_reg       <= lh_next;
        lp_reg       <= lp_next;
        ins_reg      <= ins_next;
        sc_reg       <= sc_next;
        p_reg        <= p_next;
        n_reg        <= n_next;
        evk_reg      <= evk_next;
        pred_reg     <= pred_next;
        acc_reg      <= acc_next;
        empty_reg    <= empty_next;
        r_hit_reg    <= r_hit_next;
        r_promo_reg  <= r_promo_next;
        r_ev_reg     <= r_ev_next;
        r_evk_reg    <= r_evk_next;
        r_rem_reg    <= r_rem_next;
        o_hit_reg    <= o_hit_next;
        o_promo_reg  <= o_promo_next;
        o_ev_reg     <= o_ev_next;
        o_evk_reg    <= o_evk_next;
        o_rem_reg    <= o_rem_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = ov_reg;
    assign hit         = o_hit_reg;
    assign promoted    = o_promo_reg;
    assign evicted     = o_ev_reg;
    assign evicted_key = o_evk_reg;
    assign removed     = o_rem_reg;

    `LPDP_ASSERT_SAME(a_occ_matches_valid, clk, rst_n, 1'b1, $countones(valid_reg) == occ_reg, "occupancy count differs from valid slots")
    `LPDP_ASSERT_SAME(a_ends_valid, clk, rst_n, (state_reg == S_IDLE) && (occ_reg != '0), valid_reg[head_reg] && valid_reg[tail_reg], "list head or tail names an empty slot")
    `LPDP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "accepted a second beat while busy")
    `LPDP_ASSERT_SAME(a_one_result_kind, clk, rst_n, out_valid, $onehot0({hit, evicted, removed}), "result flags overlap")

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the LRU store with predicted-delay promotion.
`timescale 1ns / 1ps
module tb_top;

    localparam int SLOTS = 256;
    localparam int FRAC  = 16;

    typedef struct packed {
        logic        hit;
        logic        promoted;
        logic        evicted;
        logic [31:0] evicted_key;
        logic        removed;
    } verdict_t;

    typedef struct packed {
        logic        act;
        logic [31:0] key;
        logic        typed;
        verdict_t    want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [lpdp_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [lpdp_pkg::CFG_W-1:0]      cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = lpdp_pkg::ACT_GET;
    logic [31:0] obj_key = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        hit, promoted, evicted, removed;
    logic [31:0] evicted_key;

    verdict_t    pending_verdicts[$];
    int          fail_count = 0;
    bit          quiet = 1'b0;
    int          beats_sent = 0;

    // Shadow copy of the store
    logic [15:0] pct_q16;
    logic [8:0]  slot_limit;
    logic [31:0] slot_key[SLOTS];
    bit          slot_live[SLOTS];
    logic [7:0]  link_next[SLOTS];
    logic [7:0]  link_prev[SLOTS];
    logic [7:0]  head_slot, tail_slot;
    int          live_count;
    logic [31:0] req_clock;
    logic [39:0] age_estimate;
    logic [31:0] hit_stamp[SLOTS];
    logic [31:0] promo_stamp[SLOTS];
    logic [31:0] insert_stamp[SLOTS];
    bit          ever_hit[SLOTS];
    logic [16:0] reuse_scale[SLOTS];

    lru_predicted_delay_promotion DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .obj_key(obj_key),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit), .promoted(promoted), .evicted(evicted),
        .evicted_key(evicted_key), .removed(removed)
    );

    always #1 clk = ~clk;

    // Detach a slot from the recency list
    function automatic void detach_slot(input logic [7:0] s);
        logic [7:0] p;
        logic [7:0] n;
        p = link_prev[s];
        n = link_next[s];
        if (head_slot == s && tail_slot == s)
            return;
        if (head_slot == s)
            head_slot = n;
        else
            link_next[p] = n;
        if (tail_slot == s)
            tail_slot = p;
        else
            link_prev[n] = p;
    endfunction

    function automatic void place_at_head(input logic [7:0] s, input bit empty_list);
        link_prev[s] = s;
        if (empty_list) begin
            link_next[s] = s;
            head_slot = s;
            tail_slot = s;
        end else begin
            link_next[s] = head_slot;
            link_prev[head_slot] = s;
            head_slot = s;
        end
    endfunction

    // Work out the response to one beat and advance the shadow store
    function automatic verdict_t store_response(input logic act, input logic [31:0] key);
        verdict_t r;
        int found;
        int lim;
        int s;
        bit got;
        logic [63:0] interval, elapsed, t, pred, age;
        longint signed remaining;
        r = '0;
        found = -1;
        for (int i = 0; i < SLOTS; i++)
            if (found < 0 && slot_live[i] && slot_key[i] == key)
                found = i;
        if (act == lpdp_pkg::ACT_REMOVE) begin
            if (found >= 0) begin
                detach_slot(found[7:0]);
                slot_live[found] = 1'b0;
                live_count--;
                r.removed = 1'b1;
            end
            return r;
        end
        req_clock = req_clock + 32'd1;
        if (found >= 0) begin
            s = found;
            interval = {32'd0, req_clock - hit_stamp[s]};
            elapsed  = {32'd0, req_clock - promo_stamp[s]};
            t = (interval * {48'd0, pct_q16}) >> 8;
            pred = (t * {47'd0, reuse_scale[s]}) >> FRAC;
            remaining = longint'({24'd0, age_estimate}) - longint'(elapsed << 8);
            r.hit = 1'b1;
            hit_stamp[s] = req_clock;
            ever_hit[s] = 1'b1;
            reuse_scale[s] = 17'(({47'd0, reuse_scale[s]} * {48'd0, pct_q16}) >> 16);
            if (longint'(pred) > remaining && pred < {24'd0, age_estimate}) begin
                if (head_slot != s[7:0]) begin
                    detach_slot(s[7:0]);
                    place_at_head(s[7:0], 1'b0);
                end
                promo_stamp[s] = req_clock;
                r.promoted = 1'b1;
            end
            return r;
        end
        lim = slot_limit;
        if (lim == 0) lim = 1;
        if (lim > SLOTS) lim = SLOTS;
        got = 1'b0;
        s = 0;
        if (live_count >= lim && live_count > 0) begin
            s = tail_slot;
            if (!ever_hit[s]) begin
                age = {32'd0, req_clock - insert_stamp[s]};
                age_estimate = 40'((64'(lpdp_pkg::W_NEW) * (age << 8)
                                   + 64'(lpdp_pkg::W_OLD) * {24'd0, age_estimate}) >> 16);
            end
            detach_slot(s[7:0]);
            slot_live[s] = 1'b0;
            live_count--;
            r.evicted = 1'b1;
            r.evicted_key = slot_key[s];
            got = 1'b1;
        end else begin
            for (int i = 0; i < SLOTS; i++)
                if (!got && !slot_live[i]) begin
                    s = i;
                    got = 1'b1;
                end
        end
        if (got) begin
            slot_key[s] = key;
            slot_live[s] = 1'b1;
            hit_stamp[s] = req_clock;
            promo_stamp[s] = req_clock;
            insert_stamp[s] = req_clock;
            ever_hit[s] = 1'b0;
            reuse_scale[s] = 17'h10000;
            place_at_head(s[7:0], live_count == 0);
            live_count++;
        end
        return r;
    endfunction

    // Drive one beat; called at a falling edge, returns at a falling edge
    task automatic send_beat(input logic act, input logic [31:0] key,
                             input bit typed, input verdict_t want);
        verdict_t got_v;
        if (!quiet && $urandom_range(99) < 14) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        obj_key  <= key;
        do @(posedge clk); while (!in_ready);
        got_v = store_response(act, key);
        pending_verdicts.push_back(typed ? want : got_v);
        beats_sent++;
        @(negedge clk);
    endtask

    // Hold the sender until every response is back
    task automatic drain_responses();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_verdicts.size() != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [lpdp_pkg::CFG_ADDR_W-1:0] idx, input int val);
        drain_responses();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= lpdp_pkg::CFG_W'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == lpdp_pkg::CFG_PERCENTILE)
            pct_q16 = 16'(val);
        else
            slot_limit = 9'(val);
    endtask

    // One random phase over a small key pool
    task automatic run_phase(input int pct, input int lim, input int pool_n, input int beats);
        logic [31:0] pool[$];
        logic [31:0] k;
        int r;
        write_reg(lpdp_pkg::CFG_PERCENTILE, pct);
        write_reg(lpdp_pkg::CFG_ACTIVE, lim);
        for (int i = 0; i < pool_n; i++)
            pool.push_back($urandom());
        for (int i = 0; i < beats; i++) begin
            r = $urandom_range(99);
            k = (r < 5) ? $urandom() : pool[$urandom_range(pool_n - 1)];
            quiet = (beats_sent >= 300 && beats_sent < 400);
            send_beat((r >= 85) ? lpdp_pkg::ACT_REMOVE : lpdp_pkg::ACT_GET, k, 1'b0, '0);
        end
    endtask

    // Sink side: random back-pressure
    always @(negedge clk)
        out_ready <= quiet || ($urandom_range(99) >= 14);

    // Compare each response beat with the oldest expectation
    always @(posedge clk) begin
        verdict_t w;
        if (rst_n && out_valid && out_ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("response beat with nothing expected");
                fail_count++;
            end else begin
                w = pending_verdicts.pop_front();
                if (hit !== w.hit) begin
                    $error("hit: expected %0d, got %0d", w.hit, hit);
                    fail_count++;
                end
                if (promoted !== w.promoted) begin
                    $error("promoted: expected %0d, got %0d", w.promoted, promoted);
                    fail_count++;
                end
                if (evicted !== w.evicted) begin
                    $error("evicted: expected %0d, got %0d", w.evicted, evicted);
                    fail_count++;
                end
                if (evicted_key !== w.evicted_key) begin
                    $error("evicted_key: expected %h, got %h", w.evicted_key, evicted_key);
                    fail_count++;
                end
                if (removed !== w.removed) begin
                    $error("removed: expected %0d, got %0d", w.removed, removed);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        stim_row_t rows[$];
        verdict_t none;
        verdict_t hit_only;
        verdict_t gone;
        none = '0;
        hit_only = '0;
        hit_only.hit = 1'b1;
        gone = '0;
        gone.removed = 1'b1;
        pct_q16 = lpdp_pkg::PCT_RESET;
        slot_limit = lpdp_pkg::LIMIT_RESET;
        for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
        head_slot = '0;
        tail_slot = '0;
        live_count = 0;
        req_clock = '0;
        age_estimate = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows: empty store, extreme keys, hit with zero age, removes
        rows.push_back({lpdp_pkg::ACT_REMOVE, 32'h0000_0005, 1'b1, none});
        rows.push_back({lpdp_pkg::ACT_GET,    32'h0000_0000, 1'b1, none});
        rows.push_back({lpdp_pkg::ACT_GET,    32'hFFFF_FFFF, 1'b1, none});
        rows.push_back({lpdp_pkg::ACT_GET,    32'h0000_0000, 1'b1, hit_only});
        rows.push_back({lpdp_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 1'b1, gone});
        rows.push_back({lpdp_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 1'b1, none});
        rows.push_back({lpdp_pkg::ACT_GET,    32'hAAAA_5555, 1'b0, none});
        rows.push_back({lpdp_pkg::ACT_GET,    32'h5555_AAAA, 1'b0, none});
        rows.push_back({lpdp_pkg::ACT_GET,    32'hAAAA_5555, 1'b1, hit_only});
        rows.push_back({lpdp_pkg::ACT_GET,    32'h0000_0000, 1'b0, none});
        rows.push_back({lpdp_pkg::ACT_REMOVE, 32'h0000_0000, 1'b1, gone});
        rows.push_back({lpdp_pkg::ACT_REMOVE, 32'hAAAA_5555, 1'b1, gone});
        rows.push_back({lpdp_pkg::ACT_REMOVE, 32'h5555_AAAA, 1'b1, gone});
        rows.push_back({lpdp_pkg::ACT_GET,    32'h8000_0001, 1'b1, none});
        foreach (rows[i])
            send_beat(rows[i].act, rows[i].key, rows[i].typed, rows[i].want);

        // Random phases; some of them drop the limit below occupancy
        run_phase(58982, 8, 20, 90);
        run_phase(0, 1, 4, 60);
        run_phase(65535, 0, 6, 70);
        run_phase(30000, 511, 40, 110);
        run_phase(50000, 4, 12, 90);
        drain_responses();
        run_phase(62000, 16, 30, 100);
        run_phase(58982, 256, 24, 116);

        drain_responses();
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
